/* design/sine_cosine_series_unit_core_assert.svh */
// Assertion macros shared by the sine and cosine series unit.
`ifndef SINE_COSINE_SERIES_UNIT_CORE_ASSERT_SVH
`define SINE_COSINE_SERIES_UNIT_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCSU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/scsu_pkg.sv */
package scsu_pkg;

  localparam int SERIES_TERMS    = 10;
  localparam int ANGLE_FRAC_BITS = 24;
  localparam int WORK_FRAC       = 48;

  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
  localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;

  localparam int RED_STEPS = 29 - ANGLE_FRAC_BITS;
  localparam int RED_CNT_W = $clog2(RED_STEPS + 1);
  localparam logic [63:0] RED_TOP =
    (TWO_PI_Q60 >> (28 - ANGLE_FRAC_BITS)) << (RED_STEPS - 1);
  localparam int RED_SH = ANGLE_FRAC_BITS + 32 - WORK_FRAC;
  localparam logic [63:0] RED_RND = (RED_SH > 0) ? (64'd1 << (RED_SH - 1)) : 64'd0;

  localparam int HT_W  = ANGLE_FRAC_BITS + 1;
  localparam int HT_SH = ANGLE_FRAC_BITS + 60 - WORK_FRAC;

  localparam int TERM_W  = $clog2(SERIES_TERMS + 1);
  localparam int DIV_MAX = 2 * SERIES_TERMS * (2 * SERIES_TERMS + 1);
  localparam int DIV_W   = $clog2(DIV_MAX + 1);
  localparam int DIV_STEP_BITS = 8;
  localparam int DIV_CYCLES    = 64 / DIV_STEP_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

  localparam int OUT_SH = WORK_FRAC - 30;

  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);

  localparam logic [63:0] ONE_WORK      = 64'd1 << WORK_FRAC;
  localparam logic [31:0] ONE_Q30       = 32'h4000_0000;
  localparam logic [31:0] MINUS_ONE_Q30 = 32'hC000_0000;

  localparam logic CMD_SINE       = 1'b0;
  localparam logic CMD_COSINE     = 1'b1;
  localparam logic UNIT_RADIAN    = 1'b0;
  localparam logic UNIT_HALF_TURN = 1'b1;

  typedef struct packed {
    logic        special;
    logic        cosine;
    logic        neg;
    logic        half;
    logic [31:0] mag;
    logic [31:0] value;
  } item_t;

  function automatic logic [DIV_W-1:0] series_div(input logic [TERM_W-1:0] idx,
                                                  input logic cosine);
    int n;
    n = 2 * int'(idx);
    return cosine ? DIV_W'(n * (n - 1)) : DIV_W'(n * (n + 1));
  endfunction

endpackage

/* design/scsu_front.sv */
module scsu_front import scsu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               queue_full,
  input  logic               in_command,
  input  logic signed [31:0] in_angle,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  output logic               push,
  output item_t              item
);

  localparam logic [1:0] QUAD_ZERO        = 2'd0;
  localparam logic [1:0] QUAD_HALF        = 2'd1;
  localparam logic [1:0] QUAD_ONE         = 2'd2;
  localparam logic [1:0] QUAD_THREE_HALVES = 2'd3;

  logic            angle_unit_r;
  logic            angle_unit_nxt;
  logic            neg;
  logic [31:0]     mag;
  logic [HT_W-1:0] rem;
  logic [1:0]      quad;
  logic            exact;
  logic            cosine;
  logic [31:0]     spec_value;

  assign angle_unit_nxt = cfg_wr_en ? cfg_wr_data : angle_unit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_unit_r <= UNIT_RADIAN;
    end else begin
      angle_unit_r <= angle_unit_nxt;
    end
  end

  assign neg    = in_angle[31];
  assign mag    = neg ? (32'd0 - $unsigned(in_angle)) : $unsigned(in_angle);
  assign rem    = mag[HT_W-1:0];
  assign quad   = rem[HT_W-1 -: 2];
  assign exact  = (rem[ANGLE_FRAC_BITS-2:0] == '0);
  assign cosine = (in_command == CMD_COSINE);

  always_comb begin
    spec_value = 32'd0;
    if (cosine) begin
      case (quad)
        QUAD_ZERO: spec_value = ONE_Q30;
        QUAD_ONE:  spec_value = MINUS_ONE_Q30;
        default:   spec_value = 32'd0;
      endcase
    end else begin
      case (quad)
        QUAD_HALF:         spec_value = neg ? MINUS_ONE_Q30 : ONE_Q30;
        QUAD_THREE_HALVES: spec_value = neg ? ONE_Q30 : MINUS_ONE_Q30;
        default:           spec_value = 32'd0;
      endcase
    end
  end

  assign push         = start & ~queue_full;
  assign item.special = (angle_unit_r == UNIT_HALF_TURN) & exact;
  assign item.cosine  = cosine;
  assign item.neg     = neg;
  assign item.half    = (angle_unit_r == UNIT_HALF_TURN);
  assign item.mag     = mag;
  assign item.value   = spec_value;

endmodule

/* design/scsu_queue.sv */
module scsu_queue import scsu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  empty,
  output logic  full
);

  item_t           slot_r [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_r;
  logic [QP_W-1:0] rd_ptr_r;
  logic [QP_W:0]   count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign head  = slot_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == (QP_W + 1)'(QUEUE_DEPTH));

endmodule

/* design/scsu_mul.sv */
module scsu_mul import scsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        sel_ht,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] result,
  output logic        done
);

  localparam logic [2:0] LAST_PART = 3'd4;
  localparam logic [2:0] ROUND_CNT = 3'd5;

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic         sel_ht_r;
  logic [2:0]   cnt_r;
  logic         run_r;
  logic         pv_r;
  logic [63:0]  prod_r;
  logic [1:0]   off_r;
  logic [127:0] acc_r;
  logic [63:0]  res_r;
  logic         done_r;
  logic [31:0]  a_part;
  logic [31:0]  b_part;
  logic [63:0]  part_prod;
  logic [127:0] addend;
  logic [127:0] rnd_ht;
  logic [127:0] rnd_wk;
  logic [63:0]  rounded;

  assign a_part    = cnt_r[0] ? a_r[63:32] : a_r[31:0];
  assign b_part    = cnt_r[1] ? b_r[63:32] : b_r[31:0];
  assign part_prod = a_part * b_part;

  always_comb begin
    case (off_r)
      2'd0:    addend = {64'd0, prod_r};
      2'd1:    addend = {32'd0, prod_r, 32'd0};
      default: addend = {prod_r, 64'd0};
    endcase
  end

  assign rnd_ht  = acc_r + (128'd1 << (HT_SH - 1));
  assign rnd_wk  = acc_r + (128'd1 << (WORK_FRAC - 1));
  assign rounded = sel_ht_r ? 64'(rnd_ht >> HT_SH) : 64'(rnd_wk >> WORK_FRAC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      pv_r   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        pv_r  <= 1'b0;
      end else if (run_r) begin
        pv_r  <= (cnt_r < LAST_PART);
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ROUND_CNT) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r      <= a;
      b_r      <= b;
      sel_ht_r <= sel_ht;
      acc_r    <= '0;
    end else if (run_r) begin
      prod_r <= part_prod;
      off_r  <= {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
      if (pv_r) begin
        acc_r <= acc_r + addend;
      end
      if (cnt_r == ROUND_CNT) begin
        res_r <= rounded;
      end
    end
  end

  assign result = res_r;
  assign done   = done_r;

endmodule

/* design/scsu_div.sv */
module scsu_div import scsu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [63:0]      num,
  input  logic [DIV_W-1:0] den,
  output logic [63:0]      quot,
  output logic             done
);

  logic [63:0]          n_r;
  logic [DIV_W-1:0]     den_r;
  logic [DIV_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 run_r;
  logic                 done_r;
  logic [63:0]          n_nxt;
  logic [DIV_W-1:0]     rem_nxt;

  always_comb begin
    logic [DIV_W:0] trial;
    logic           qbit;
    n_nxt   = n_r;
    rem_nxt = rem_r;
    for (int j = 0; j < DIV_STEP_BITS; j++) begin
      trial = {rem_nxt, n_nxt[63]};
      qbit  = (trial >= {1'b0, den_r});
      if (qbit) begin
        trial = trial - {1'b0, den_r};
      end
      n_nxt   = {n_nxt[62:0], qbit};
      rem_nxt = trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num + 64'(den >> 1);
      den_r <= den;
      rem_r <= '0;
    end else if (run_r) begin
      n_r   <= n_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quot = n_r;
  assign done = done_r;

endmodule

/* design/scsu_back.sv */
`include "sine_cosine_series_unit_core_assert.svh"

module scsu_back import scsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  item_t       head,
  output logic        pop,
  output logic        out_strobe,
  output logic [31:0] out_value
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_RED  = 9'b000000010,
    ST_HMUL = 9'b000000100,
    ST_SQ   = 9'b000001000,
    ST_SQW  = 9'b000010000,
    ST_ACC  = 9'b000100000,
    ST_TMUL = 9'b001000000,
    ST_TDIV = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_t;

  localparam int V_W = 64 - OUT_SH;

  state_t                state_r;
  state_t                state_nxt;
  logic                  out_strobe_r;
  logic                  out_strobe_nxt;
  logic [31:0]           out_value_r;
  logic [31:0]           out_value_nxt;
  logic                  cosine_r;
  logic                  neg_r;
  logic [63:0]           red_r;
  logic [63:0]           pd_r;
  logic [RED_CNT_W-1:0]  red_cnt_r;
  logic [63:0]           xm_r;
  logic [63:0]           x2_r;
  logic [63:0]           t_mag_r;
  logic                  t_neg_r;
  logic signed [63:0]    sum_r;
  logic [TERM_W-1:0]     term_r;

  logic                  mul_start;
  logic                  mul_sel_ht;
  logic [63:0]           mul_a;
  logic [63:0]           mul_b;
  logic [63:0]           mul_result;
  logic                  mul_done;
  logic                  div_start;
  logic [DIV_W-1:0]      div_den;
  logic [63:0]           div_quot;
  logic                  div_done;

  logic [63:0]           red_sub;
  logic [63:0]           red_xm;
  logic                  red_last;
  logic signed [63:0]    t_signed;
  logic [63:0]           sum_mag;
  logic [63:0]           sum_rnd;
  logic [V_W-1:0]        v;
  logic [31:0]           sat_value;

  assign red_sub  = (red_r >= pd_r) ? (red_r - pd_r) : red_r;
  assign red_xm   = 64'((red_sub + RED_RND) >> RED_SH);
  assign red_last = (red_cnt_r == RED_CNT_W'(RED_STEPS - 1));
  assign t_signed = t_neg_r ? -$signed(t_mag_r) : $signed(t_mag_r);

  assign sum_mag = sum_r[63] ? (64'd0 - $unsigned(sum_r)) : $unsigned(sum_r);
  assign sum_rnd = sum_mag + (64'd1 << (OUT_SH - 1));
  assign v       = sum_rnd[63:OUT_SH];

  always_comb begin
    if (sum_r[63]) begin
      sat_value = (v > V_W'(33'h0_8000_0000)) ? 32'h8000_0000 : (32'd0 - v[31:0]);
    end else begin
      sat_value = (v > V_W'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : v[31:0];
    end
  end

  assign mul_sel_ht = (state_r == ST_IDLE);
  assign mul_a = (state_r == ST_IDLE) ? 64'(head.mag[HT_W-1:0]) :
                 (state_r == ST_SQ)   ? xm_r : t_mag_r;
  assign mul_b = (state_r == ST_IDLE) ? PI_Q60 :
                 (state_r == ST_SQ)   ? xm_r : x2_r;
  assign div_den = series_div(term_r, cosine_r);

  scsu_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .sel_ht (mul_sel_ht),
    .a      (mul_a),
    .b      (mul_b),
    .result (mul_result),
    .done   (mul_done)
  );

  scsu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mul_result),
    .den   (div_den),
    .quot  (div_quot),
    .done  (div_done)
  );

  always_comb begin
    state_nxt      = state_r;
    pop            = 1'b0;
    mul_start      = 1'b0;
    div_start      = 1'b0;
    out_strobe_nxt = 1'b0;
    out_value_nxt  = out_value_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (head.special) begin
            out_strobe_nxt = 1'b1;
            out_value_nxt  = head.value;
          end else if (head.half) begin
            mul_start = 1'b1;
            state_nxt = ST_HMUL;
          end else begin
            state_nxt = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (red_last) begin
          state_nxt = ST_SQ;
        end
      end
      ST_HMUL: begin
        if (mul_done) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        mul_start = 1'b1;
        state_nxt = ST_SQW;
      end
      ST_SQW: begin
        if (mul_done) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (term_r == TERM_W'(SERIES_TERMS)) begin
          state_nxt = ST_FIN;
        end else begin
          mul_start = 1'b1;
          state_nxt = ST_TMUL;
        end
      end
      ST_TMUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_nxt = ST_TDIV;
        end
      end
      ST_TDIV: begin
        if (div_done) begin
          state_nxt = ST_ACC;
        end
      end
      ST_FIN: begin
        out_strobe_nxt = 1'b1;
        out_value_nxt  = sat_value;
        state_nxt      = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          cosine_r  <= head.cosine;
          neg_r     <= head.neg;
          red_r     <= {head.mag, 32'd0};
          pd_r      <= RED_TOP;
          red_cnt_r <= '0;
        end
      end
      ST_RED: begin
        red_r     <= red_sub;
        pd_r      <= pd_r >> 1;
        red_cnt_r <= red_cnt_r + 1'b1;
        if (red_last) begin
          xm_r <= red_xm;
        end
      end
      ST_HMUL: begin
        if (mul_done) begin
          xm_r <= mul_result;
        end
      end
      ST_SQW: begin
        if (mul_done) begin
          x2_r    <= mul_result;
          t_mag_r <= cosine_r ? ONE_WORK : xm_r;
          t_neg_r <= cosine_r ? 1'b0 : neg_r;
          sum_r   <= '0;
          term_r  <= TERM_W'(1);
        end
      end
      ST_ACC: begin
        sum_r <= sum_r + t_signed;
      end
      ST_TDIV: begin
        if (div_done) begin
          t_mag_r <= div_quot;
          t_neg_r <= ~t_neg_r;
          term_r  <= term_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_strobe = out_strobe_r;
  assign out_value  = out_value_r;

  `SCSU_ASSERT_SAME(a_mul_done_state,
    mul_done, (state_r == ST_HMUL || state_r == ST_SQW || state_r == ST_TMUL),
    "Multiplier finished outside a multiply wait state.")
  `SCSU_ASSERT_SAME(a_div_done_state, div_done, (state_r == ST_TDIV),
    "Divider finished outside the divide wait state.")
  `SCSU_ASSERT_SAME(a_term_range, (state_r == ST_ACC),
    (term_r != '0 && term_r <= TERM_W'(SERIES_TERMS)),
    "Series term index out of range during accumulation.")
  `SCSU_ASSERT_NEXT(a_fin_strobe, (state_r == ST_FIN), (out_strobe_r && state_r == ST_IDLE),
    "Finished series did not produce a result transfer.")

endmodule

/* design/sine_cosine_series_unit_core.sv */
// Channel   Ports                                   Transfer
// input     start, busy, in_command, in_angle       start high while busy is low
// config    cfg_wr_en, cfg_wr_data                  cfg_wr_en high
// result    out_strobe, out_value                   out_strobe high, one cycle
// The run time of a radian item and of a half-turn item is set by
// the shared 32x32 multiplier, four partial products per product, and the divider, which
// retires eight quotient bits per cycle, for each of the nine later series terms.
// An exact half-turn point skips the series; its result is held in the queue and registered.
// The two-entry queue takes new items while the series runs; busy is high when it is full.
// Synchronous reset empties the queue and selects radians; results are never held off.
module sine_cosine_series_unit_core import scsu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic signed [31:0] in_angle,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  output logic               out_strobe,
  output logic signed [31:0] out_value
);

  logic        push;
  logic        pop;
  logic        q_empty;
  logic        q_full;
  item_t       push_item;
  item_t       head;
  logic [31:0] value;

  scsu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .queue_full  (q_full),
    .in_command  (in_command),
    .in_angle    (in_angle),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push),
    .item        (push_item)
  );

  scsu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  scsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .head       (head),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_value  (value)
  );

  assign busy      = q_full;
  assign out_value = $signed(value);

endmodule
